@@ rtl/tape_level_playback_unit_defines.svh @@
// Assertion macros for the tape level playback unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TAPE_LEVEL_PLAYBACK_UNIT_DEFINES_SVH
`define TAPE_LEVEL_PLAYBACK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define TLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tlp check failed");

`define TLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tlp check failed");

`else

`define TLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define TLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/tlp_pkg.sv @@
// Shared types and constants for the tape level playback unit.
// Used by the sequencer, the segment memory and the top level.
package tlp_pkg;

    localparam int OP_BITS         = 3;
    localparam int IDX_BITS        = 8;
    localparam int DUR_BITS        = 32;
    localparam int LVL_IN_BITS     = 8;
    localparam int TICK_IN_BITS    = 32;
    localparam int CNT_BITS        = 9;

    localparam int DEF_SEGMENT_DEPTH = 256;
    localparam int DEF_TICK_BITS     = 32;

    localparam int IN_FIELD_BITS = IDX_BITS + DUR_BITS + LVL_IN_BITS + TICK_IN_BITS + 1;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_LOAD    = 3'd0,
        OP_START   = 3'd1,
        OP_REWIND  = 3'd2,
        OP_MOTOR   = 3'd3,
        OP_ADVANCE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LVL0,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic motor_running;
        logic end_reached;
        logic ear_out;
        logic status;
    } t_result;

endpackage

@@ rtl/tlp_seg_mem.sv @@
// Segment table: one write port, one read port with registered read data.
// Holds duration and level per entry; uses tlp_pkg.
module tlp_seg_mem #(
    parameter int SEGMENT_DEPTH = tlp_pkg::DEF_SEGMENT_DEPTH,
    parameter int AW = 8
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [tlp_pkg::DUR_BITS-1:0]  i_wdur,
    input  logic                          i_wlvl,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [tlp_pkg::DUR_BITS-1:0]  o_rdur,
    output logic                          o_rlvl
);
    import tlp_pkg::*;

    logic [DUR_BITS:0] r_mem [SEGMENT_DEPTH];
    logic [DUR_BITS:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wlvl, i_wdur};
        end
        if (i_re) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    assign o_rdur = r_rd[DUR_BITS-1:0];
    assign o_rlvl = r_rd[DUR_BITS];

endmodule

@@ rtl/tlp_seq.sv @@
// Operation sequencer: decodes items, walks segments through the table memory,
// holds head state and the segment count register. Uses tlp_pkg and the defines header.
`include "tape_level_playback_unit_defines.svh"

module tlp_seq #(
    parameter int SEGMENT_DEPTH = tlp_pkg::DEF_SEGMENT_DEPTH,
    parameter int TICK_BITS = tlp_pkg::DEF_TICK_BITS,
    parameter int AW = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [tlp_pkg::CNT_BITS-1:0]      i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [tlp_pkg::OP_BITS-1:0]       i_op,
    input  logic [tlp_pkg::IDX_BITS-1:0]      i_entry_index,
    input  logic [tlp_pkg::DUR_BITS-1:0]      i_entry_duration,
    input  logic [tlp_pkg::LVL_IN_BITS-1:0]   i_entry_level,
    input  logic [tlp_pkg::TICK_IN_BITS-1:0]  i_tick_count,
    input  logic                              i_motor_request,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output tlp_pkg::t_result                  o_res,
    output logic                              o_mem_we,
    output logic [AW-1:0]                     o_mem_waddr,
    output logic [tlp_pkg::DUR_BITS-1:0]      o_mem_wdur,
    output logic                              o_mem_wlvl,
    output logic                              o_mem_re,
    output logic [AW-1:0]                     o_mem_raddr,
    input  logic [tlp_pkg::DUR_BITS-1:0]      i_mem_rdur,
    input  logic                              i_mem_rlvl
);
    import tlp_pkg::*;

    localparam int CMPW = (AW + 1 > CNT_BITS) ? AW + 1 : CNT_BITS;

    t_state                 r_state, n_state;
    logic [CNT_BITS-1:0]    r_seg_count;
    logic [CNT_BITS-1:0]    r_active, n_active;
    logic [AW-1:0]          r_pos, n_pos;
    logic [TICK_BITS-1:0]   r_elapsed, n_elapsed;
    logic [TICK_BITS-1:0]   r_remaining, n_remaining;
    logic                   r_ear, n_ear;
    logic                   r_motor, n_motor;
    logic                   r_end, n_end;
    logic                   r_started, n_started;
    logic                   r_pend, n_pend;
    logic                   r_status, n_status;

    logic                   accept;
    logic                   load_ok;
    logic                   start_ok;
    logic                   adv_go;
    logic [TICK_BITS-1:0]   dur_m;
    logic [TICK_BITS-1:0]   avail;
    logic                   run_stay;
    logic [CMPW-1:0]        pos_nx;
    logic                   run_last;
    logic                   run_cross;

    assign accept   = i_in_valid && o_in_ready;
    assign load_ok  = (32'(i_entry_index) < 32'(SEGMENT_DEPTH))
                      && (i_entry_duration != '0)
                      && (i_entry_level[LVL_IN_BITS-1:1] == '0);
    assign start_ok = (r_seg_count != '0) && (32'(r_seg_count) <= 32'(SEGMENT_DEPTH));
    assign adv_go   = r_started && r_motor && !r_end && (TICK_BITS'(i_tick_count) != '0);

    assign dur_m     = TICK_BITS'(i_mem_rdur);
    assign avail     = (dur_m > r_elapsed) ? dur_m - r_elapsed : '0;
    assign run_stay  = r_remaining < avail;
    assign pos_nx    = CMPW'(r_pos) + CMPW'(1);
    assign run_last  = pos_nx >= CMPW'(r_active);
    assign run_cross = (r_state == S_RUN) && (r_remaining != '0) && !run_stay && !run_last;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DONE;
                    unique case (i_op)
                        OP_START:   if (start_ok) n_state = S_LVL0;
                        OP_REWIND:  if (r_started) n_state = S_LVL0;
                        OP_ADVANCE: if (adv_go) n_state = S_RUN;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_LVL0: n_state = S_DONE;
            S_RUN:  if (!run_cross) n_state = S_DONE;
            S_DONE: if (i_res_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_active    = r_active;
        n_pos       = r_pos;
        n_elapsed   = r_elapsed;
        n_remaining = r_remaining;
        n_ear       = r_ear;
        n_motor     = r_motor;
        n_end       = r_end;
        n_started   = r_started;
        n_pend      = r_pend;
        n_status    = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = 1'b0;
                    n_pend   = 1'b0;
                    unique case (i_op)
                        OP_LOAD: n_status = !load_ok;
                        OP_START: begin
                            if (start_ok) begin
                                n_active  = r_seg_count;
                                n_started = 1'b1;
                                n_motor   = 1'b0;
                                n_pos     = '0;
                                n_elapsed = '0;
                                n_end     = 1'b0;
                            end else begin
                                n_status = 1'b1;
                            end
                        end
                        OP_REWIND: begin
                            if (r_started) begin
                                n_pos     = '0;
                                n_elapsed = '0;
                                n_end     = 1'b0;
                            end else begin
                                n_status = 1'b1;
                            end
                        end
                        OP_MOTOR: begin
                            if (r_started) n_motor = i_motor_request && !r_end;
                            else n_status = 1'b1;
                        end
                        OP_ADVANCE: begin
                            n_status    = !r_started;
                            n_remaining = TICK_BITS'(i_tick_count);
                        end
                        default: n_status = 1'b1;
                    endcase
                end
            end
            S_LVL0: n_ear = i_mem_rlvl;
            S_RUN: begin
                n_pend = 1'b0;
                if (r_pend) n_ear = i_mem_rlvl;
                if (r_remaining != '0) begin
                    if (run_stay) begin
                        n_elapsed   = r_elapsed + r_remaining;
                        n_remaining = '0;
                    end else begin
                        n_remaining = r_remaining - avail;
                        n_elapsed   = '0;
                        if (run_last) begin
                            n_pos = AW'(r_active - CNT_BITS'(1));
                            n_ear = i_mem_rlvl;
                            n_end = 1'b1;
                        end else begin
                            n_pos  = AW'(pos_nx);
                            n_pend = 1'b1;
                        end
                    end
                end
            end
            S_DONE: n_pend = 1'b0;
            default: n_pend = 1'b0;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_res_valid = (r_state == S_DONE);
        o_res       = '{motor_running: r_motor, end_reached: r_end,
                        ear_out: r_ear, status: r_status};
        o_mem_we    = accept && (i_op == OP_LOAD) && load_ok;
        o_mem_waddr = AW'(i_entry_index);
        o_mem_wdur  = i_entry_duration;
        o_mem_wlvl  = i_entry_level[0];
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        if (accept) begin
            unique case (i_op)
                OP_START:   o_mem_re = start_ok;
                OP_REWIND:  o_mem_re = r_started;
                OP_ADVANCE: begin
                    o_mem_re    = adv_go;
                    o_mem_raddr = r_pos;
                end
                default:    o_mem_re = 1'b0;
            endcase
        end else if (run_cross) begin
            o_mem_re    = 1'b1;
            o_mem_raddr = AW'(pos_nx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seg_count <= '0;
            r_active    <= '0;
            r_pos       <= '0;
            r_elapsed   <= '0;
            r_ear       <= 1'b0;
            r_motor     <= 1'b0;
            r_end       <= 1'b0;
            r_started   <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_wr_en) r_seg_count <= i_cfg_wr_data;
            r_active    <= n_active;
            r_pos       <= n_pos;
            r_elapsed   <= n_elapsed;
            r_ear       <= n_ear;
            r_motor     <= n_motor;
            r_end       <= n_end;
            r_started   <= n_started;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_remaining <= n_remaining;
        r_status    <= n_status;
    end

    `TLP_ASSERT_IMP(a_no_rw_overlap, i_clk, i_rst_n, o_mem_we, !o_mem_re)
    `TLP_ASSERT_IMP(a_run_in_range, i_clk, i_rst_n, r_state == S_RUN,
        CMPW'(r_pos) < CMPW'(r_active))
    `TLP_ASSERT_IMP(a_run_needs_motor, i_clk, i_rst_n, r_state == S_RUN,
        r_started && r_motor && !r_end)
    `TLP_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `TLP_ASSERT_IMP(a_pend_after_read, i_clk, i_rst_n, r_pend,
        r_state == S_RUN && $past(o_mem_re))

endmodule

@@ rtl/tape_level_playback_unit.sv @@
// Tape level playback unit. Load, set_motor, an idle advance and rejected items go
// straight from decode to the result state; start and rewind first pass the level
// fetch state; a running advance that moves the head forward k segments stays in the
// run state (one table read per move). Items are taken only after the previous result
// enters the output register. Synchronous active-low reset clears head state, flags and
// segment count; the segment table is not cleared and holds unknown data until loaded.
module tape_level_playback_unit #(
    parameter int SEGMENT_DEPTH = tlp_pkg::DEF_SEGMENT_DEPTH,
    parameter int TICK_BITS = tlp_pkg::DEF_TICK_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [tlp_pkg::CNT_BITS-1:0]       i_cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // entry_index[7:0], entry_duration[39:8], entry_level[47:40],
    // tick_count[79:48], motor_request[80], zero fill above
    input  logic [tlp_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // operation[2:0]
    input  logic [tlp_pkg::OP_BITS-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status[0], ear_out[1], end_reached[2], motor_running[3], zero fill above
    output logic [tlp_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);
    import tlp_pkg::*;

    localparam int AW = (SEGMENT_DEPTH > 1) ? $clog2(SEGMENT_DEPTH) : 1;

    localparam int IX_LO = 0;
    localparam int DU_LO = IX_LO + IDX_BITS;
    localparam int LV_LO = DU_LO + DUR_BITS;
    localparam int TK_LO = LV_LO + LVL_IN_BITS;
    localparam int MR_LO = TK_LO + TICK_IN_BITS;

    logic                 res_valid;
    logic                 res_ready;
    t_result              res;
    logic                 r_out_valid;
    t_result              r_out_res;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DUR_BITS-1:0]  mem_wdur;
    logic                 mem_wlvl;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [DUR_BITS-1:0]  mem_rdur;
    logic                 mem_rlvl;

    tlp_seq #(
        .SEGMENT_DEPTH (SEGMENT_DEPTH),
        .TICK_BITS     (TICK_BITS),
        .AW            (AW)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (s_axis_tvalid),
        .o_in_ready       (s_axis_tready),
        .i_op             (s_axis_tuser),
        .i_entry_index    (s_axis_tdata[DU_LO-1:IX_LO]),
        .i_entry_duration (s_axis_tdata[LV_LO-1:DU_LO]),
        .i_entry_level    (s_axis_tdata[TK_LO-1:LV_LO]),
        .i_tick_count     (s_axis_tdata[MR_LO-1:TK_LO]),
        .i_motor_request  (s_axis_tdata[MR_LO]),
        .o_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .o_res            (res),
        .o_mem_we         (mem_we),
        .o_mem_waddr      (mem_waddr),
        .o_mem_wdur       (mem_wdur),
        .o_mem_wlvl       (mem_wlvl),
        .o_mem_re         (mem_re),
        .o_mem_raddr      (mem_raddr),
        .i_mem_rdur       (mem_rdur),
        .i_mem_rlvl       (mem_rlvl)
    );

    tlp_seg_mem #(
        .SEGMENT_DEPTH (SEGMENT_DEPTH),
        .AW            (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdur  (mem_wdur),
        .i_wlvl  (mem_wlvl),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdur  (mem_rdur),
        .o_rlvl  (mem_rlvl)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_BITS'(r_out_res);

endmodule

@@ tb/tb.sv @@
// Self-checking bench for tape_level_playback_unit: directed and random streams of
// load/start/rewind/motor/advance items against a local playback predictor.
// Depends on tlp_pkg and the RTL of the unit; no files or arguments are read.
module tb;
    import tlp_pkg::*;

    localparam int SEG_DEPTH   = DEF_SEGMENT_DEPTH;
    localparam int OP_CODE_MAX = (1 << OP_BITS) - 1;
    localparam int MAX_WAIT    = 17;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 80;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [OP_BITS-1:0]      op;
        bit   [IDX_BITS-1:0]     idx;
        bit   [DUR_BITS-1:0]     dur;
        bit   [LVL_IN_BITS-1:0]  lvl;
        bit   [TICK_IN_BITS-1:0] ticks;
        bit                      req;
        bit                      drain;
        int                      gap;
    } t_tape_item;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_wr_en = 1'b0;
    logic [CNT_BITS-1:0]      i_cfg_wr_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
    logic [OP_BITS-1:0]       s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    tape_level_playback_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // playback predictor state
    bit [DUR_BITS-1:0] seg_dur [SEG_DEPTH];
    bit                seg_lvl [SEG_DEPTH];
    int                head_pos;
    bit [63:0]         head_elapsed;
    bit                ear_now;
    bit                motor_live;
    bit                at_end;
    bit                tape_started;
    int                cfg_len;
    int                run_len;
    t_result           level_reports[$];

    // stimulus state
    t_tape_item        feed_q[$];
    t_tape_item        on_bus;
    bit [SEG_DEPTH-1:0] gen_loaded;
    int                gen_len;
    bit                send_calm;
    bit                take_calm;
    int                gap_count;
    int                queued_total;
    int                sent_count;
    int                done_count;
    int                stall_left;
    int                mismatches;
    int                quiet_cycles;

    function automatic int pick_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void cue_head();
        head_pos = 0;
        head_elapsed = '0;
        ear_now = seg_lvl[0];
        at_end = 1'b0;
    endfunction

    function automatic void play_tape_item(input t_tape_item it);
        bit        bad;
        bit [63:0] left;
        bit [63:0] span;
        bit [63:0] avail;
        bad = 1'b0;
        case (it.op)
            OP_LOAD: begin
                if (it.dur == 0 || it.lvl > 1) begin
                    bad = 1'b1;
                end else begin
                    seg_dur[it.idx] = it.dur;
                    seg_lvl[it.idx] = it.lvl[0];
                end
            end
            OP_START: begin
                if (cfg_len == 0 || cfg_len > SEG_DEPTH) begin
                    bad = 1'b1;
                end else begin
                    run_len = cfg_len;
                    tape_started = 1'b1;
                    motor_live = 1'b0;
                    cue_head();
                end
            end
            OP_REWIND: begin
                if (!tape_started) bad = 1'b1;
                else cue_head();
            end
            OP_MOTOR: begin
                if (!tape_started) bad = 1'b1;
                else motor_live = it.req && !at_end;
            end
            OP_ADVANCE: begin
                if (!tape_started) begin
                    bad = 1'b1;
                end else if (motor_live && !at_end) begin
                    left = 64'(it.ticks);
                    while (left != 0 && !at_end) begin
                        if (head_pos >= run_len) begin
                            at_end = 1'b1;
                        end else begin
                            span = 64'(seg_dur[head_pos]);
                            avail = (span > head_elapsed) ? span - head_elapsed : 64'd0;
                            if (left < avail) begin
                                head_elapsed += left;
                                left = '0;
                            end else begin
                                left -= avail;
                                head_elapsed = '0;
                                if (head_pos + 1 >= run_len) begin
                                    ear_now = seg_lvl[head_pos];
                                    head_pos = run_len - 1;
                                    at_end = 1'b1;
                                end else begin
                                    head_pos++;
                                    ear_now = seg_lvl[head_pos];
                                end
                            end
                        end
                    end
                end
            end
            default: bad = 1'b1;
        endcase
        level_reports.push_back(t_result'{motor_running: motor_live, end_reached: at_end,
                                          ear_out: ear_now, status: bad});
    endfunction

    task automatic queue_item(input int op, input int idx,
            input bit [DUR_BITS-1:0] dur, input int lvl,
            input bit [TICK_IN_BITS-1:0] ticks, input bit req, input bit drain);
        t_tape_item it;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        it.op = OP_BITS'(op);
        it.idx = IDX_BITS'(idx);
        it.dur = dur;
        it.lvl = LVL_IN_BITS'(lvl);
        it.ticks = ticks;
        it.req = req;
        it.drain = drain;
        it.gap = pick_wait(send_calm);
        if (it.op == OP_LOAD && dur != 0 && it.lvl <= 1) gen_loaded[it.idx] = 1'b1;
        feed_q.push_back(it);
        queued_total++;
    endtask

    task automatic queue_random_phase(input int count);
        int                    e;
        int                    n;
        int                    r;
        int                    op;
        int                    idx;
        bit [DUR_BITS-1:0]     dur;
        int                    lvl;
        bit [TICK_IN_BITS-1:0] ticks;
        // fill every entry the new tape length will read, then mount it
        for (e = 0; e < gen_len; e++) begin
            if (!gen_loaded[e])
                queue_item(OP_LOAD, e, $urandom_range(1, 24), $urandom_range(0, 1), $urandom(),
                           $urandom_range(0, 1) != 0, 1'b0);
        end
        queue_item(OP_START, $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom_range(0, 1) != 0, 1'b0);
        for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 7) op = OP_START;
            else if (r < 20) op = OP_MOTOR;
            else if (r < 58) op = OP_ADVANCE;
            else if (r < 65) op = OP_REWIND;
            else if (r < 95) op = OP_LOAD;
            else op = $urandom_range(OP_ADVANCE + 1, OP_CODE_MAX);
            idx = $urandom_range(0, 1) ? $urandom_range(0, gen_len - 1)
                                       : $urandom_range(0, SEG_DEPTH - 1);
            case ($urandom_range(0, 9))
                0: dur = '0;
                1: dur = $urandom();
                default: dur = $urandom_range(1, 24);
            endcase
            lvl = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 255) : $urandom_range(0, 1);
            case ($urandom_range(0, 9))
                0: ticks = '0;
                1: ticks = $urandom();
                default: ticks = $urandom_range(1, 40);
            endcase
            queue_item(op, idx, dur, lvl, ticks, $urandom_range(0, 3) != 0,
                       $urandom_range(0, 49) == 0);
        end
    endtask

    task automatic settle();
        do @(posedge i_clk);
        while (sent_count != queued_total || done_count != sent_count);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_tape_len(input int len);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= CNT_BITS'(len);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_len = len;
        gen_len = len;
        @(negedge i_clk);
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_count <= 0;
            sent_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                play_tape_item(on_bus);
                sent_count <= sent_count + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (feed_q.size() != 0 && gap_count >= feed_q[0].gap &&
                        (!feed_q[0].drain || (!s_axis_tvalid && sent_count == done_count))) begin
                    on_bus <= feed_q[0];
                    s_axis_tdata <= {7'b0, feed_q[0].req, feed_q[0].ticks, feed_q[0].lvl,
                                     feed_q[0].dur, feed_q[0].idx};
                    s_axis_tuser <= feed_q[0].op;
                    s_axis_tvalid <= 1'b1;
                    gap_count <= 0;
                    void'(feed_q.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                    gap_count <= gap_count + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin : take_side
        t_result got;
        t_result want;
        int      stall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
            done_count <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            if (level_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d: got %b with no item pending", done_count, got);
            end else begin
                want = level_reports.pop_front();
                if (got.status !== want.status || got.ear_out !== want.ear_out ||
                        got.end_reached !== want.end_reached ||
                        got.motor_running !== want.motor_running) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d: status/ear/end/motor exp %b %b %b %b got %b %b %b %b",
                                 done_count, want.status, want.ear_out, want.end_reached,
                                 want.motor_running, got.status, got.ear_out, got.end_reached,
                                 got.motor_running);
                end
            end
            done_count <= done_count + 1;
            if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
            stall = pick_wait(take_calm);
            stall_left <= stall;
            m_axis_tready <= (stall == 0);
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : run_tape
        int k;
        int len;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_tape_len(0);

        // nothing mounted yet: reject everything but loads
        queue_item(OP_ADVANCE, 0, 0, 0, 5, 1'b1, 1'b0);
        queue_item(OP_MOTOR, 0, 0, 0, 0, 1'b1, 1'b0);
        queue_item(OP_REWIND, 0, 0, 0, 0, 1'b0, 1'b0);
        queue_item(OP_START, 0, 0, 0, 0, 1'b0, 1'b0);
        for (k = OP_ADVANCE + 1; k <= OP_CODE_MAX; k++)
            queue_item(k, 255, 32'hFFFF_FFFF, 255, 32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_item(OP_LOAD, 0, 0, 1, 0, 1'b0, 1'b0);
        queue_item(OP_LOAD, 1, 5, 2, 0, 1'b0, 1'b0);
        queue_item(OP_LOAD, 2, 9, 255, 0, 1'b0, 1'b0);
        queue_item(OP_LOAD, 0, 3, 1, 0, 1'b0, 1'b0);
        queue_item(OP_LOAD, 1, 32'hFFFF_FFFF, 0, 0, 1'b0, 1'b0);
        queue_item(OP_LOAD, 2, 1, 1, 0, 1'b0, 1'b0);
        queue_item(OP_LOAD, 255, 7, 0, 0, 1'b0, 1'b0);
        settle();
        write_tape_len(3);

        // three-segment tape: idle advances, multi-segment crossing, end and rewind
        queue_item(OP_START, 0, 0, 0, 0, 1'b0, 1'b0);
        queue_item(OP_ADVANCE, 0, 0, 0, 10, 1'b0, 1'b0);
        queue_item(OP_MOTOR, 0, 0, 0, 0, 1'b1, 1'b0);
        queue_item(OP_ADVANCE, 0, 0, 0, 0, 1'b0, 1'b0);
        queue_item(OP_ADVANCE, 0, 0, 0, 2, 1'b0, 1'b0);
        queue_item(OP_LOAD, 1, 4, 0, 0, 1'b0, 1'b0);
        queue_item(OP_ADVANCE, 0, 0, 0, 6, 1'b0, 1'b0);
        queue_item(OP_ADVANCE, 0, 0, 0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_item(OP_REWIND, 0, 0, 0, 0, 1'b0, 1'b1);
        queue_item(OP_ADVANCE, 0, 0, 0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_item(OP_MOTOR, 0, 0, 0, 0, 1'b1, 1'b0);
        settle();
        write_tape_len(1);

        // length changed without a new start: playback keeps the mounted length
        queue_item(OP_REWIND, 0, 0, 0, 0, 1'b0, 1'b0);
        queue_random_phase(PHASE_ITEMS);

        for (k = 0; k < 6; k++) begin
            if (k == 0) len = SEG_DEPTH;
            else if (k == 1) len = 2;
            else if (k == 2) len = $urandom_range(192, SEG_DEPTH - 1);
            else len = $urandom_range(1, 40);
            settle();
            write_tape_len(len);
            queue_random_phase(PHASE_ITEMS);
        end

        settle();
        if (mismatches == 0 && level_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/tlp_pkg.sv
rtl/tlp_seg_mem.sv
rtl/tlp_seq.sv
rtl/tape_level_playback_unit.sv
tb/tb.sv
